>>> rtl/q8d_pkg.sv
// ----------------------------------------------------------------------------
// q8d_pkg
// Shared types, constants and float helpers of the Q8_0 row dot product core.
// ----------------------------------------------------------------------------
package q8d_pkg;

    // block geometry of the quantised format (values and bytes per block)
    localparam int BLOCK_VALUES = 32;
    localparam int BLOCK_BYTES  = 34;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

    // one input request
    typedef struct packed {
        logic [15:0]       block_scale;
        logic signed [7:0] weight_value;
        logic [31:0]       activation;
        logic              last_in_row;
    } t_in_item;

    // one result request
    typedef struct packed {
        logic [31:0] row_sum;
    } t_out_item;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_MUL,
        S_TRM,
        S_ADD,
        S_NRM
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic dec;
        logic mul;
        logic trm;
        logic add;
        logic commit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last;
        logic out_busy;
    } t_sts;

    // round sign * n * 2^e to single precision, nearest even, with subnormals
    function automatic logic [31:0] round_pack(input logic sgn, input logic [41:0] n,
                                               input logic signed [11:0] e);
        logic [5:0]         p;
        logic signed [11:0] s;
        logic signed [11:0] s2;
        logic [65:0]        w;
        logic [65:0]        q;
        logic [65:0]        h;
        logic [65:0]        mask;
        logic               rb;
        logic               st;
        logic [24:0]        r;
        logic [11:0]        fe;
        logic [34:0]        val;
        logic [31:0]        res;
        p = 6'd0;
        for (int i = 0; i < 42; i++) begin
            if (n[i]) p = 6'(i);
        end
        s  = $signed({6'b0, p}) - 12'sd23;
        s2 = -12'sd149 - e;
        if (s2 > s) s = s2;
        w    = {n, 24'b0};
        q    = w >> 7'(s + 12'sd24);
        h    = w >> 7'(s + 12'sd23);
        rb   = h[0];
        mask = (66'd1 << 7'(s + 12'sd23)) - 66'd1;
        st   = |(w & mask);
        r    = q[24:0] + {24'b0, rb & (st | q[0])};
        fe   = 12'(s + e + 12'sd149);
        val  = {fe, 23'b0} + {10'b0, r};
        if (n == 42'd0) begin
            res = {sgn, 31'b0};
        end else if (val >= {4'b0, INF_MAG}) begin
            res = {sgn, INF_MAG};
        end else begin
            res = {sgn, val[30:0]};
        end
        return res;
    endfunction

endpackage

>>> rtl/q8d_stream_if.sv
// ----------------------------------------------------------------------------
// q8d_stream_if
// Valid/ready channel carrying one request payload of a chosen type.
// ----------------------------------------------------------------------------
interface q8d_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/q8_0_row_dot_f32_core.sv
// ----------------------------------------------------------------------------
// q8_0_row_dot_f32_core
// Streaming Q8_0 row dot product with a single-precision accumulator.
// ----------------------------------------------------------------------------
// One request is taken at a time and walks from acceptance to the
// accumulator update through decode and exact scale*weight, the 18x24 significand
// multiply, product rounding, alignment add, then sum rounding and commit.
// The next request can be accepted in the cycle after the commit, so a new
// element is not taken before the last one is committed.
// A row sum waits in an output register; the commit of the next row end
// holds only while that register is still unclaimed.
module q8_0_row_dot_f32_core (
    input logic      i_clk,
    input logic      i_rst_n,
    q8d_stream_if.sink   i_in,
    q8d_stream_if.source o_out
);
    import q8d_pkg::*;

    t_cmd      cmd;
    t_sts      sts;
    t_out_item out_item;

    q8d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    q8d_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in.payload),
        .i_out_ready (o_out.ready),
        .o_sts       (sts),
        .o_out_valid (o_out.valid),
        .o_out_item  (out_item)
    );

    assign o_out.payload = out_item;
endmodule

>>> rtl/q8d_ctrl.sv
// ----------------------------------------------------------------------------
// q8d_ctrl
// Sequencer: walks one request through decode, multiply, round, add, commit.
// ----------------------------------------------------------------------------
module q8d_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  q8d_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output q8d_pkg::t_cmd o_cmd
);
    import q8d_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.dec = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_TRM;
            end
            S_TRM: begin
                o_cmd.trm = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_NRM;
            end
            S_NRM: begin
                // hold while a finished row sum is still unclaimed
                if (!(i_sts.last && i_sts.out_busy)) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

>>> rtl/q8d_dpath.sv
// ----------------------------------------------------------------------------
// q8d_dpath
// Datapath: half decode, exact scale*weight, product rounding, float add.
// ----------------------------------------------------------------------------
module q8d_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  q8d_pkg::t_cmd       i_cmd,
    input  q8d_pkg::t_in_item   i_item,
    input  logic                i_out_ready,
    output q8d_pkg::t_sts       o_sts,
    output logic                o_out_valid,
    output q8d_pkg::t_out_item  o_out_item
);
    import q8d_pkg::*;

    // captured request
    logic [15:0]        r_scale;
    logic [7:0]         r_wt;
    logic [31:0]        r_act;
    logic               r_last;

    // decode stage
    logic [17:0]        r_m1w;
    logic signed [11:0] r_e1;
    logic [23:0]        r_m2;
    logic signed [11:0] r_e2;
    logic               r_hs_inf, r_hs_nan, r_w_zero;
    logic               r_a_inf, r_a_nan, r_a_zero, r_sgn;

    // multiply stage
    logic [41:0]        r_prod;
    logic signed [11:0] r_pe;
    logic               r_t_nan, r_t_inf, r_t_sgn;

    // rounded term
    logic [31:0]        r_term;

    // add stage
    logic [41:0]        r_sum_n;
    logic signed [11:0] r_sum_e;
    logic               r_sum_sgn, r_zsgn, r_spec;
    logic [31:0]        r_spec_bits;

    // accumulator and output
    logic [31:0]        r_acc;
    logic               r_out_valid;
    logic [31:0]        r_out;

    // decode combinational
    logic [4:0]         h_exp;
    logic [10:0]        m1;
    logic signed [11:0] e1;
    logic [7:0]         w_abs;
    logic [17:0]        m1w_full;
    logic [7:0]         a_exp;

    always_comb begin
        h_exp = r_scale[14:10];
        if (h_exp == 5'd0) begin
            m1 = {1'b0, r_scale[9:0]};
            e1 = -12'sd24;
        end else begin
            m1 = {1'b1, r_scale[9:0]};
            e1 = $signed({7'b0, h_exp}) - 12'sd25;
        end
        w_abs    = r_wt[7] ? 8'(-r_wt) : r_wt;
        m1w_full = 18'(m1) * 18'(w_abs);
        a_exp    = r_act[30:23];
    end

    // add combinational
    logic               sa, sb, sx, sy;
    logic [23:0]        ma, mb, mx, my;
    logic signed [11:0] ea, eb, ex, ey;
    logic signed [11:0] dd_full;
    logic [4:0]         dd;
    logic [26:0]        av, bf, bs, bmask, bj;
    logic [27:0]        nsum;
    logic [27:0]        ndif;
    logic [27:0]        nres;
    logic               sres;
    logic               acc_nan, acc_inf, trm_nan, trm_inf;
    logic               spec;
    logic [31:0]        spec_bits;

    always_comb begin
        sa = r_acc[31];
        sb = r_term[31];
        ma = {(r_acc[30:23] != 8'd0), r_acc[22:0]};
        mb = {(r_term[30:23] != 8'd0), r_term[22:0]};
        ea = (r_acc[30:23] == 8'd0) ? -12'sd149 : $signed({4'b0, r_acc[30:23]}) - 12'sd150;
        eb = (r_term[30:23] == 8'd0) ? -12'sd149 : $signed({4'b0, r_term[30:23]}) - 12'sd150;
        // larger exponent first
        if (eb > ea) begin
            sx = sb; mx = mb; ex = eb; sy = sa; my = ma; ey = ea;
        end else begin
            sx = sa; mx = ma; ex = ea; sy = sb; my = mb; ey = eb;
        end
        dd_full = ex - ey;
        dd      = (dd_full > 12'sd27) ? 5'd27 : dd_full[4:0];
        av      = {mx, 3'b0};
        bf      = {my, 3'b0};
        bs      = bf >> dd;
        bmask   = (27'd1 << dd) - 27'd1;
        bj      = bs | {26'b0, |(bf & bmask)};
        nsum    = {1'b0, av} + {1'b0, bj};
        ndif    = {1'b0, av} - {1'b0, bj};
        if (sx == sy) begin
            nres = nsum;
            sres = sx;
        end else if (ndif[27]) begin
            nres = 28'(-ndif);
            sres = sy;
        end else begin
            nres = ndif;
            sres = sx;
        end
        // infinity and nan operands
        acc_nan = (r_acc[30:23] == 8'hFF) && (r_acc[22:0] != 23'd0);
        acc_inf = (r_acc[30:23] == 8'hFF) && (r_acc[22:0] == 23'd0);
        trm_nan = (r_term[30:23] == 8'hFF) && (r_term[22:0] != 23'd0);
        trm_inf = (r_term[30:23] == 8'hFF) && (r_term[22:0] == 23'd0);
        spec      = acc_nan || trm_nan || acc_inf || trm_inf;
        spec_bits = CANON_NAN;
        if (acc_nan || trm_nan || (acc_inf && trm_inf && (sa != sb))) begin
            spec_bits = CANON_NAN;
        end else if (acc_inf) begin
            spec_bits = {sa, INF_MAG};
        end else if (trm_inf) begin
            spec_bits = {sb, INF_MAG};
        end
    end

    logic [31:0] sum_bits;
    logic [31:0] out_bits;

    // final rounding of the sum
    always_comb begin
        if (r_spec) begin
            sum_bits = r_spec_bits;
        end else begin
            sum_bits = round_pack((r_sum_n == 42'd0) ? r_zsgn : r_sum_sgn, r_sum_n, r_sum_e);
        end
        if ((sum_bits[30:23] == 8'hFF) && (sum_bits[22:0] != 23'd0)) begin
            out_bits = CANON_NAN;
        end else begin
            out_bits = sum_bits;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_scale <= i_item.block_scale;
            r_wt    <= i_item.weight_value;
            r_act   <= i_item.activation;
            r_last  <= i_item.last_in_row;
        end
        if (i_cmd.dec) begin
            r_m1w    <= m1w_full;
            r_e1     <= e1;
            r_m2     <= {(a_exp != 8'd0), r_act[22:0]};
            r_e2     <= (a_exp == 8'd0) ? -12'sd149 : $signed({4'b0, a_exp}) - 12'sd150;
            r_hs_inf <= (h_exp == 5'h1F) && (r_scale[9:0] == 10'd0);
            r_hs_nan <= (h_exp == 5'h1F) && (r_scale[9:0] != 10'd0);
            r_w_zero <= (r_wt == 8'd0);
            r_a_inf  <= (a_exp == 8'hFF) && (r_act[22:0] == 23'd0);
            r_a_nan  <= (a_exp == 8'hFF) && (r_act[22:0] != 23'd0);
            r_a_zero <= (r_act[30:0] == 31'd0);
            r_sgn    <= r_scale[15] ^ r_wt[7] ^ r_act[31];
        end
        if (i_cmd.mul) begin
            r_prod  <= 42'(r_m1w) * 42'(r_m2);
            r_pe    <= r_e1 + r_e2;
            // scaled inf times zero, or zero times inf, is invalid
            r_t_nan <= r_hs_nan || r_a_nan || (r_hs_inf && r_w_zero)
                    || (r_hs_inf && r_a_zero) || (!r_hs_inf && r_m1w == 18'd0 && r_a_inf);
            r_t_inf <= r_hs_inf || r_a_inf;
            r_t_sgn <= r_sgn;
        end
        if (i_cmd.trm) begin
            if (r_t_nan) begin
                r_term <= CANON_NAN;
            end else if (r_t_inf) begin
                r_term <= {r_t_sgn, INF_MAG};
            end else begin
                r_term <= round_pack(r_t_sgn, r_prod, r_pe);
            end
        end
        if (i_cmd.add) begin
            r_sum_n     <= {14'b0, nres};
            r_sum_e     <= ex - 12'sd3;
            r_sum_sgn   <= sres;
            r_zsgn      <= sa & sb;
            r_spec      <= spec;
            r_spec_bits <= spec_bits;
        end
        if (i_cmd.commit && r_last) begin
            r_out <= out_bits;
        end
    end

    // accumulator and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_acc <= r_last ? 32'd0 : sum_bits;
            end
            if (i_cmd.commit && r_last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.last         = r_last;
    assign o_sts.out_busy     = r_out_valid && !i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_item.row_sum = r_out;
endmodule

>>> rtl/q8d_checker.sv
// ----------------------------------------------------------------------------
// q8d_checker
// Port-level checks of the row dot product core, bound to the top level.
// ----------------------------------------------------------------------------
module q8d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_last,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_sum
);
    // one request in flight: no acceptance right after another
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request accepted while another is in flight");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_sum)))
        else $error("stalled row sum dropped or changed");

    // an element that does not end a row produces no row sum
    a_no_sum_mid_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && !i_in_last) |=> ##5 !$rose(i_out_valid))
        else $error("row sum emitted for an element inside a row");

    // any emitted nan is the canonical quiet nan
    a_canon_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_sum[30:23] == 8'hFF) && (i_out_sum[22:0] != 23'd0))
        |-> (i_out_sum == 32'h7FC0_0000))
        else $error("non-canonical nan on the output");
endmodule

bind q8_0_row_dot_f32_core q8d_checker u_q8d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.payload.last_in_row),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_sum   (o_out.payload.row_sum)
);
